/* rtl/ssfr_pkg.sv */
// Shared constants and types for the sensor slave frame responder.
package ssfr_pkg;

  localparam int unsigned FrameBytes = 6;
  localparam int unsigned PosW       = $clog2(FrameBytes);

  localparam logic [7:0]  HdrByte      = 8'h3A;
  localparam logic [7:0]  EndByte      = 8'h0D;
  localparam logic [7:0]  FcnRead      = 8'h02;
  localparam logic [7:0]  SlaveIdReset = 8'h02;
  localparam logic [15:0] RegTemp      = 16'h0001;
  localparam logic [15:0] RegHumid     = 16'h0002;

  localparam logic [15:0] SilentValue = 16'd200;
  localparam logic [15:0] BadSumValue = 16'd100;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [15:0] RecipTen = 16'hCCCD;
  localparam int unsigned DivShift = 19;

  typedef enum logic [1:0] {
    SelZero,
    SelTemp,
    SelHumid
  } reg_sel_e;

  typedef enum logic [2:0] {
    PosHdr,
    PosId,
    PosFcn,
    PosValHi,
    PosValLo,
    PosEnd
  } reply_pos_e;

  typedef struct packed {
    logic     start;
    reg_sel_e sel;
  } reply_req_t;

  typedef struct packed {
    logic       responded;
    logic [7:0] humid_high;
    logic [7:0] humid_low;
    logic [7:0] temp_high;
    logic [7:0] temp_low;
    logic [7:0] check_byte;
  } sensor_word_t;

endpackage

/* rtl/sensor_slave_frame_responder_unit.sv */
// Top level of the sensor slave frame responder.
// Bus slave that assembles six-word request frames (header 0x3A, id, function, register high,
// register low, end 0x0D) and answers read requests (function 0x02) addressed to slave_id with
// a six-word reply: 0x3A, id, 0x02, value high, value low, 0x0D; m_axis_tlast marks the final
// word. Register 1 reads temperature, register 2 humidity, any other register reads zero. Words
// before a header are dropped; a frame with a wrong id, end word or function is dropped silently.
// Sensor words (tuser = 1) latch a reading: raw/10 for both values, 200/200 when the sensor did
// not respond, 100/100 on a checksum mismatch, 0/0 when the raw temperature sign bit is set.
// Rate: one input word per cycle while s_axis_tready is high. The reply serializer sends one
// word per m_axis_tready handshake; its first word is valid in the cycle after the
// closing request word is taken. While a reply is being sent, input stays open until the open
// frame is down to its closing word; from then on every input word, sensor words included,
// waits and is taken at the earliest in the cycle after the reply's final word is taken. The
// slave_id register is written through the cfg channel, which is always ready; write it only
// while the block is idle. No clearing pass after reset.
module sensor_slave_frame_responder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: slave_id
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte, [8] sensor_responded, [16:9] humid_high, [24:17] humid_low,
  // [32:25] temp_high, [40:33] temp_low, [48:41] check_byte, [55:49] zero
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // op: 0 bus word, 1 sensor reading
  // reply words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] tx_byte
  output logic        m_axis_tlast    // last_byte
);
  import ssfr_pkg::*;

  logic         [7:0] slave_id_q;
  logic               accept;
  logic               byte_we, sensor_we;
  logic               frame_last, busy;
  logic        [15:0] temp, humid;
  reply_req_t         req;
  sensor_word_t       sensor_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_id_q <= SlaveIdReset;
    end else if (cfg_valid_i) begin
      slave_id_q <= cfg_data_i;
    end
  end

  // only a frame-closing word can start a reply, so while busy hold off all input at the closing word
  assign s_axis_tready = !busy || !frame_last;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign byte_we       = accept && !s_axis_tuser;
  assign sensor_we     = accept && s_axis_tuser;

  assign sensor_word.responded  = s_axis_tdata[8];
  assign sensor_word.humid_high = s_axis_tdata[16:9];
  assign sensor_word.humid_low  = s_axis_tdata[24:17];
  assign sensor_word.temp_high  = s_axis_tdata[32:25];
  assign sensor_word.temp_low   = s_axis_tdata[40:33];
  assign sensor_word.check_byte = s_axis_tdata[48:41];

  ssfr_sensor_decode u_sensor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (sensor_we),
    .word_i  (sensor_word),
    .temp_o  (temp),
    .humid_o (humid)
  );

  ssfr_frame_rx u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_we_i    (byte_we),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .slave_id_i   (slave_id_q),
    .req_o        (req),
    .frame_last_o (frame_last)
  );

  ssfr_reply_tx u_reply (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .temp_i        (temp),
    .humid_i       (humid),
    .slave_id_i    (slave_id_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .busy_o        (busy)
  );

endmodule

/* rtl/ssfr_sensor_decode.sv */
// Sensor reading checker and scaler: latches temperature and humidity.
module ssfr_sensor_decode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  ssfr_pkg::sensor_word_t word_i,
  output logic [15:0]          temp_o,
  output logic [15:0]          humid_o
);
  import ssfr_pkg::*;

  logic [15:0] temp_q, temp_d;
  logic [15:0] humid_q, humid_d;
  logic [15:0] raw_t, raw_h;
  logic [7:0]  sum;
  logic [31:0] t_prod, h_prod, t_shr, h_shr;

  assign raw_t = {word_i.temp_high, word_i.temp_low};
  assign raw_h = {word_i.humid_high, word_i.humid_low};
  assign sum   = word_i.humid_high + word_i.humid_low + word_i.temp_high + word_i.temp_low;

  assign t_prod = 32'(raw_t) * 32'(RecipTen);
  assign h_prod = 32'(raw_h) * 32'(RecipTen);
  assign t_shr  = t_prod >> DivShift;
  assign h_shr  = h_prod >> DivShift;

  always_comb begin
    temp_d  = temp_q;
    humid_d = humid_q;
    if (we_i) begin
      if (!word_i.responded) begin
        temp_d  = SilentValue;
        humid_d = SilentValue;
      end else if (sum != word_i.check_byte) begin
        temp_d  = BadSumValue;
        humid_d = BadSumValue;
      end else if (raw_t[15]) begin
        temp_d  = '0;
        humid_d = '0;
      end else begin
        temp_d  = t_shr[15:0];
        humid_d = h_shr[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= '0;
      humid_q <= '0;
    end else begin
      temp_q  <= temp_d;
      humid_q <= humid_d;
    end
  end

  assign temp_o  = temp_q;
  assign humid_o = humid_q;

endmodule

/* rtl/ssfr_frame_rx.sv */
// Request frame assembler and checker.
module ssfr_frame_rx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_we_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           slave_id_i,
  output ssfr_pkg::reply_req_t req_o,
  output logic                 frame_last_o
);
  import ssfr_pkg::*;

  logic            open_q, open_d;
  logic [PosW-1:0] pos_q, pos_d;
  // last frame byte is checked on the fly and never stored
  logic [7:0]      req_q [FrameBytes-1];
  logic            is_last, take, done, match;
  logic [15:0]     reg_addr;

  assign is_last = (pos_q == PosW'(FrameBytes - 1));
  assign take    = byte_we_i && (open_q || (rx_byte_i == HdrByte));
  assign done    = take && open_q && is_last;

  always_comb begin
    open_d = open_q;
    pos_d  = pos_q;
    if (take) begin
      if (done) begin
        open_d = 1'b0;
        pos_d  = '0;
      end else begin
        open_d = 1'b1;
        pos_d  = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      open_q <= open_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !is_last) begin
      req_q[pos_q] <= rx_byte_i;
    end
  end

  assign match    = (req_q[1] == slave_id_i) && (rx_byte_i == EndByte) && (req_q[2] == FcnRead);
  assign reg_addr = {req_q[3], req_q[4]};

  always_comb begin
    req_o.start = done && match;
    if (reg_addr == RegTemp) begin
      req_o.sel = SelTemp;
    end else if (reg_addr == RegHumid) begin
      req_o.sel = SelHumid;
    end else begin
      req_o.sel = SelZero;
    end
  end

  assign frame_last_o = open_q && is_last;

  a_closed_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> (pos_q == '0))
    else $error("frame position not zero while no frame is open");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(FrameBytes - 1))
    else $error("frame position out of range");

endmodule

/* rtl/ssfr_reply_tx.sv */
// Reply frame serializer: one reply word per handshake.
module ssfr_reply_tx (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssfr_pkg::reply_req_t req_i,
  input  logic [15:0]          temp_i,
  input  logic [15:0]          humid_i,
  input  logic [7:0]           slave_id_i,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [7:0] tx_byte
  output logic                 m_axis_tlast,  // last_byte
  output logic                 busy_o
);
  import ssfr_pkg::*;

  logic        busy_q, busy_d;
  reply_pos_e  pos_q, pos_d;
  logic [15:0] val_q, val_d;
  logic        fire;

  assign fire = busy_q && m_axis_tready;

  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    val_d  = val_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      pos_d  = PosHdr;
      case (req_i.sel)
        SelTemp:  val_d = temp_i;
        SelHumid: val_d = humid_i;
        default:  val_d = '0;
      endcase
    end else if (fire) begin
      if (pos_q == PosEnd) begin
        busy_d = 1'b0;
        pos_d  = PosHdr;
      end else begin
        pos_d = reply_pos_e'(pos_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= PosHdr;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_comb begin
    case (pos_q)
      PosHdr:   m_axis_tdata = HdrByte;
      PosId:    m_axis_tdata = slave_id_i;
      PosFcn:   m_axis_tdata = FcnRead;
      PosValHi: m_axis_tdata = val_q[15:8];
      PosValLo: m_axis_tdata = val_q[7:0];
      default:  m_axis_tdata = EndByte;
    endcase
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = (pos_q == PosEnd);
  assign busy_o        = busy_q;

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("reply requested while a reply is still being sent");

  a_end_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (pos_q == PosEnd)) |=> !busy_q)
    else $error("serializer still busy after final reply word");

endmodule
